@@ design/generator_voltage_regulator_top_defines.svh @@
// ----------------------------------------------------------------------------
// Generator voltage regulator: assertion macros
// Shared property forms for the clocked checks of the regulator.
// ----------------------------------------------------------------------------
`ifndef GENERATOR_VOLTAGE_REGULATOR_TOP_DEFINES_SVH
`define GENERATOR_VOLTAGE_REGULATOR_TOP_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define GVR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define GVR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/gvr_pkg.sv @@
// ----------------------------------------------------------------------------
// Generator voltage regulator package
// Widths, reset values, codes and shared types of the regulator.
// ----------------------------------------------------------------------------
package gvr_pkg;

  localparam int WINDOW_SIZE = 10;
  localparam int IDX_W       = $clog2(WINDOW_SIZE);
  localparam int SAMPLE_W    = 10;
  localparam int DUTY_W      = 8;
  localparam int MODE_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int SUM_W       = $clog2(1024 * WINDOW_SIZE);

  localparam logic [DUTY_W-1:0]   DUTY_MAX  = 8'd255;
  localparam logic [SAMPLE_W-1:0] POT_FULL  = 10'd1023;
  localparam logic [SAMPLE_W-1:0] THR_RST   = 10'd262;
  localparam logic [SAMPLE_W-1:0] LOWER_RST = 10'd238;
  localparam logic [SAMPLE_W-1:0] UPPER_RST = 10'd267;

  typedef enum logic [MODE_W-1:0] {
    MODE_CMP    = 3'd0,
    MODE_STEP   = 3'd1,
    MODE_AVG    = 3'd2,
    MODE_MAX    = 3'd3,
    MODE_WINDOW = 3'd4,
    MODE_MANUAL = 3'd5
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE      = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_LOWER     = 2'd2,
    REG_UPPER     = 2'd3
  } cfg_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    WIN_OK   = 2'd0,
    WIN_LOW  = 2'd1,
    WIN_HIGH = 2'd2
  } win_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [SAMPLE_W-1:0] wr_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                acc_clr;
  } ring_ctrl_t;

endpackage

@@ design/gvr_ring.sv @@
// ----------------------------------------------------------------------------
// Sample ring
// Window memory with a registered read, per-entry valid bits and a
// sum and maximum accumulator fed by the read data.
// ----------------------------------------------------------------------------
module gvr_ring
  import gvr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ring_ctrl_t          ctrl_i,
  output logic [SUM_W-1:0]    sum_o,
  output logic [SAMPLE_W-1:0] max_o
);

  logic [SAMPLE_W-1:0]    mem_q [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0] entry_vld_q;
  logic [SAMPLE_W-1:0]    rd_data_q;
  logic [IDX_W-1:0]       rd_idx_q;
  logic                   rd_vld_q;
  logic [SUM_W-1:0]       sum_q;
  logic [SAMPLE_W-1:0]    max_q;
  logic [SAMPLE_W-1:0]    rd_word;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[ctrl_i.wr_addr] <= ctrl_i.wr_data;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[ctrl_i.rd_addr];
      rd_idx_q  <= ctrl_i.rd_addr;
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      rd_vld_q <= ctrl_i.rd_en;
      if (ctrl_i.wr_en) begin
        entry_vld_q[ctrl_i.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_word = entry_vld_q[rd_idx_q] ? rd_data_q : '0;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_clr) begin
      sum_q <= '0;
      max_q <= '0;
    end else if (rd_vld_q) begin
      sum_q <= sum_q + SUM_W'(rd_word);
      if (rd_word > max_q) begin
        max_q <= rd_word;
      end
    end
  end

  assign sum_o = sum_q;
  assign max_o = max_q;

endmodule

@@ design/generator_voltage_regulator_top.sv @@
// ----------------------------------------------------------------------------
// Generator voltage regulator
// Per-sample drive decision: comparator, duty stepping, window average,
// window maximum, dead-band stepping with status, or manual duty.
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid_i/in_stall_o sample_i, pot_sample_i
// out      output     out_valid_o/out_stall_i use_pwm_o, duty_o, level_o,
//                                           window_status_o
// cfg      input      cfg_we_i              cfg_idx_i, cfg_wdata_i
//
// In the average or maximum mode the accept cycle writes the ring, the
// sweep reads each ring entry in turn, the drain empties the read register
// and the result state loads the result. Other modes skip sweep and drain.
// Reset clears the ring valid bits, the write position and the duty counter.
// A stalled output holds its item; the next item is taken once the current
// one has moved into the output register.
// ----------------------------------------------------------------------------
module generator_voltage_regulator_top
  import gvr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [SAMPLE_W-1:0]  sample_i,
  input  logic [SAMPLE_W-1:0]  pot_sample_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 use_pwm_o,
  output logic [DUTY_W-1:0]    duty_o,
  output logic                 level_o,
  output logic [STATUS_W-1:0]  window_status_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SAMPLE_W-1:0]  cfg_wdata_i
);

  `include "generator_voltage_regulator_top_defines.svh"

  logic [MODE_W-1:0]   mode_q;
  logic [SAMPLE_W-1:0] threshold_q, lower_q, upper_q;
  state_e              state_q, state_d;
  logic [IDX_W-1:0]    cnt_q, cnt_d;
  logic [IDX_W-1:0]    wpos_q, wpos_d;
  logic [DUTY_W-1:0]   duty_cnt_q, duty_cnt_d;
  logic [SAMPLE_W-1:0] sample_q, pot_q;
  logic                out_valid_q;
  logic                use_pwm_q, level_q;
  logic [DUTY_W-1:0]   duty_q;
  logic [STATUS_W-1:0] status_q;

  ring_ctrl_t          ring_ctrl;
  logic [SUM_W-1:0]    ring_sum;
  logic [SAMPLE_W-1:0] ring_max;

  logic                in_acc, ring_mode, out_ld;
  logic                res_use_pwm, res_level;
  logic [DUTY_W-1:0]   res_duty;
  logic [STATUS_W-1:0] res_status;
  logic [SUM_W-1:0]    avg_lim;
  logic [17:0]         pot_prod;
  logic [DUTY_W-1:0]   pot_q0, pot_duty;
  logic [10:0]         pot_rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_W'(MODE_WINDOW);
      threshold_q <= THR_RST;
      lower_q     <= LOWER_RST;
      upper_q     <= UPPER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:      mode_q      <= cfg_wdata_i[MODE_W-1:0];
        REG_THRESHOLD: threshold_q <= cfg_wdata_i;
        REG_LOWER:     lower_q     <= cfg_wdata_i;
        REG_UPPER:     upper_q     <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ring_mode  = (mode_q == MODE_AVG) || (mode_q == MODE_MAX);
  assign out_ld     = (state_q == S_RESULT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d           = state_q;
    cnt_d             = cnt_q;
    wpos_d            = wpos_q;
    ring_ctrl         = '0;
    ring_ctrl.wr_addr = wpos_q;
    ring_ctrl.wr_data = sample_i;
    ring_ctrl.rd_addr = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (ring_mode) begin
            ring_ctrl.wr_en   = 1'b1;
            ring_ctrl.acc_clr = 1'b1;
            wpos_d  = (wpos_q == IDX_W'(WINDOW_SIZE - 1)) ? '0 : wpos_q + 1'b1;
            cnt_d   = '0;
            state_d = S_SWEEP;
          end else begin
            state_d = S_RESULT;
          end
        end
      end
      S_SWEEP: begin
        ring_ctrl.rd_en = 1'b1;
        if (cnt_q == IDX_W'(WINDOW_SIZE - 1)) begin
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DRAIN: begin
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_ld) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The average is at most the threshold exactly when the window sum stays
  // below (threshold + 1) * WINDOW_SIZE.
  assign avg_lim = SUM_W'(threshold_q) * SUM_W'(WINDOW_SIZE) + SUM_W'(WINDOW_SIZE - 1);

  // Manual duty: pot * 255 / 1023 with a shift estimate and one correction.
  assign pot_prod = {pot_q, 8'b0} - 18'(pot_q);
  assign pot_q0   = pot_prod[17:10];
  assign pot_rem  = {1'b0, pot_prod[9:0]} + 11'(pot_q0);
  assign pot_duty = (pot_rem >= 11'(POT_FULL)) ? pot_q0 + 1'b1 : pot_q0;

  always_comb begin
    res_use_pwm = 1'b0;
    res_duty    = '0;
    res_level   = 1'b0;
    res_status  = WIN_OK;
    duty_cnt_d  = duty_cnt_q;
    case (mode_q)
      MODE_STEP: begin
        if (sample_q > threshold_q) begin
          if (duty_cnt_q != '0) begin
            duty_cnt_d = duty_cnt_q - 1'b1;
          end
        end else if (duty_cnt_q != DUTY_MAX) begin
          duty_cnt_d = duty_cnt_q + 1'b1;
        end
        res_use_pwm = 1'b1;
        res_duty    = duty_cnt_d;
      end
      MODE_AVG: begin
        res_level = (ring_sum <= avg_lim);
      end
      MODE_MAX: begin
        res_level = (ring_max <= threshold_q);
      end
      MODE_WINDOW: begin
        if (sample_q < lower_q) begin
          res_status = WIN_LOW;
          if (duty_cnt_q != DUTY_MAX) begin
            duty_cnt_d = duty_cnt_q + 1'b1;
          end
        end else if (sample_q > upper_q) begin
          res_status = WIN_HIGH;
          if (duty_cnt_q != '0) begin
            duty_cnt_d = duty_cnt_q - 1'b1;
          end
        end
        res_use_pwm = 1'b1;
        res_duty    = duty_cnt_d;
      end
      MODE_MANUAL: begin
        res_use_pwm = 1'b1;
        res_duty    = pot_duty;
      end
      default: begin
        res_level = (sample_q <= threshold_q);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      wpos_q      <= '0;
      duty_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wpos_q  <= wpos_d;
      if (out_ld) begin
        duty_cnt_q  <= duty_cnt_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= sample_i;
      pot_q    <= pot_sample_i;
    end
    if (out_ld) begin
      use_pwm_q <= res_use_pwm;
      duty_q    <= res_duty;
      level_q   <= res_level;
      status_q  <= res_status;
    end
  end

  gvr_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ring_ctrl),
    .sum_o  (ring_sum),
    .max_o  (ring_max)
  );

  assign out_valid_o     = out_valid_q;
  assign use_pwm_o       = use_pwm_q;
  assign duty_o          = duty_q;
  assign level_o         = level_q;
  assign window_status_o = status_q;

  `GVR_ASSERT_NEXT(a_accept_blocks, in_acc, in_stall_o, "item accepted while busy")
  `GVR_ASSERT_NOW(a_sweep_mode, state_q == S_SWEEP, ring_mode, "ring sweep outside ring modes")
  `GVR_ASSERT_NOW(a_result_src, $rose(out_valid_q), $past(state_q) == S_RESULT, "result without work")
  `GVR_ASSERT_NEXT(a_duty_step, 1'b1, (duty_cnt_q == $past(duty_cnt_q)) || (duty_cnt_q == $past(duty_cnt_q) + 8'd1) || (duty_cnt_q == $past(duty_cnt_q) - 8'd1), "duty counter jumped")

endmodule
